[src/rfc_pkg.sv]
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the CRC-8 byte update for the response framer.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CAP_W       = 11;
    localparam int unsigned ENTRY_MAX   = 5;
    localparam int unsigned COUNT_W     = $clog2(ENTRY_MAX + 1);
    localparam int unsigned IDX_W       = $clog2(ENTRY_MAX);
    localparam int unsigned IN_DATA_W   = 4 * BYTE_W;

    // Largest payload length that a header may announce.
    localparam int unsigned PAYLOAD_MAX = 255;
    // Sync, code, status and length bytes plus the trailing CRC.
    localparam int unsigned HDR_AND_CRC = 5;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    // Configuration register indexes.
    localparam logic CFG_SYNC_BYTE   = 1'b0;
    localparam logic CFG_TX_CAPACITY = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST   = 8'h00;
    localparam logic [CAP_W-1:0]  TX_CAPACITY_RST = 11'd260;

    // Input item kinds.
    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // What one queued result entry does when it is sent.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,  // send the byte and fold it into the CRC
        KIND_CRC  = 2'd1,  // send the running CRC and close the frame
        KIND_ERR  = 2'd2   // send the overflow marker
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t       kind;
        logic [BYTE_W-1:0] value;
    } entry_t;

    // All results caused by one accepted item, in order.
    typedef struct packed {
        logic                        restart;  // first entry starts from CRC_INIT
        logic [COUNT_W-1:0]          count;
        entry_t [ENTRY_MAX-1:0]      entries;
    } bundle_t;

    // MSB-first CRC-8 update of one byte.
    function automatic logic [BYTE_W-1:0] crc8_feed(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

[src/rfc_frame_ctl.sv]
// ----------------------------------------------------------------------------
// rfc_frame_ctl
// Frame bookkeeping: decides which results an accepted item causes.
// ----------------------------------------------------------------------------
module rfc_frame_ctl #(
    parameter int unsigned PAYLOAD_MAX = rfc_pkg::PAYLOAD_MAX
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           command,
    input  logic [rfc_pkg::BYTE_W-1:0]     resp_code,
    input  logic [rfc_pkg::BYTE_W-1:0]     status_code,
    input  logic [rfc_pkg::BYTE_W-1:0]     payload_len,
    input  logic [rfc_pkg::BYTE_W-1:0]     data_byte,
    input  logic [rfc_pkg::BYTE_W-1:0]     sync_byte,
    input  logic [rfc_pkg::CAP_W-1:0]      tx_capacity,
    output rfc_pkg::bundle_t               bundle
);

    logic [rfc_pkg::BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic                       discarding_reg, discarding_next;

    logic [rfc_pkg::BYTE_W:0]   frame_size;
    logic                       too_big;
    logic [rfc_pkg::BYTE_W-1:0] left_dec;

    assign frame_size = (rfc_pkg::BYTE_W+1)'(rfc_pkg::HDR_AND_CRC)
                        + {1'b0, payload_len};
    assign too_big    = ({(rfc_pkg::CAP_W-rfc_pkg::BYTE_W-1)'(0), frame_size} > tx_capacity)
                        || ({1'b0, payload_len} > (rfc_pkg::BYTE_W+1)'(PAYLOAD_MAX));
    assign left_dec   = bytes_left_reg - rfc_pkg::BYTE_W'(1);

    always_comb
    begin
        bundle          = '0;
        bytes_left_next = bytes_left_reg;
        discarding_next = discarding_reg;
        case (command)
            rfc_pkg::CMD_HEADER:
            begin
                // A header always opens a fresh frame and drops any open one.
                bundle.restart  = 1'b1;
                bytes_left_next = payload_len;
                if (too_big)
                begin
                    discarding_next              = (payload_len != '0);
                    bundle.count                 = rfc_pkg::COUNT_W'(1);
                    bundle.entries[0].kind       = rfc_pkg::KIND_ERR;
                end
                else
                begin
                    discarding_next              = 1'b0;
                    bundle.entries[0]            = '{rfc_pkg::KIND_DATA, sync_byte};
                    bundle.entries[1]            = '{rfc_pkg::KIND_DATA, resp_code};
                    bundle.entries[2]            = '{rfc_pkg::KIND_DATA, status_code};
                    bundle.entries[3]            = '{rfc_pkg::KIND_DATA, payload_len};
                    bundle.entries[4].kind       = rfc_pkg::KIND_CRC;
                    bundle.count = (payload_len == '0) ? rfc_pkg::COUNT_W'(5)
                                                       : rfc_pkg::COUNT_W'(4);
                end
            end
            rfc_pkg::CMD_PAYLOAD:
            begin
                if (bytes_left_reg != '0)
                begin
                    bytes_left_next = left_dec;
                    if (discarding_reg)
                    begin
                        discarding_next = (left_dec != '0);
                    end
                    else
                    begin
                        bundle.entries[0]      = '{rfc_pkg::KIND_DATA, data_byte};
                        bundle.entries[1].kind = rfc_pkg::KIND_CRC;
                        bundle.count = (left_dec == '0) ? rfc_pkg::COUNT_W'(2)
                                                        : rfc_pkg::COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                bundle = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            discarding_reg <= 1'b0;
        end
        else if (accept)
        begin
            bytes_left_reg <= bytes_left_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule

[src/rfc_serializer.sv]
// ----------------------------------------------------------------------------
// rfc_serializer
// Holds one item's results, sends them one per cycle while the output is not stalled, and runs the CRC.
// ----------------------------------------------------------------------------
module rfc_serializer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  rfc_pkg::bundle_t           bundle,
    output logic                       can_load,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rfc_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last,
    output logic                       out_overflow
);

    rfc_pkg::bundle_t            pend_reg;
    logic [rfc_pkg::IDX_W-1:0]   idx_reg;
    logic [rfc_pkg::COUNT_W-1:0] cnt_reg;
    logic [rfc_pkg::BYTE_W-1:0]  crc_reg, crc_next;

    logic                        out_valid_reg;
    logic [rfc_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic                        pend_has;
    logic                        out_free;
    logic                        move;
    logic                        on_final;
    rfc_pkg::entry_t             entry;
    logic [rfc_pkg::BYTE_W-1:0]  crc_base;

    assign pend_has = rfc_pkg::COUNT_W'(idx_reg) != cnt_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign move     = pend_has && out_free;
    assign on_final = rfc_pkg::COUNT_W'(idx_reg)
                      == rfc_pkg::COUNT_W'(cnt_reg - rfc_pkg::COUNT_W'(1));
    assign can_load = !pend_has || (move && on_final);

    assign entry    = pend_reg.entries[idx_reg];
    assign crc_base = (pend_reg.restart && idx_reg == '0) ? rfc_pkg::CRC_INIT : crc_reg;

    always_comb
    begin
        out_byte_next = entry.value;
        out_last_next = 1'b0;
        out_ovf_next  = 1'b0;
        crc_next      = rfc_pkg::crc8_feed(crc_base, entry.value);
        case (entry.kind)
            rfc_pkg::KIND_DATA:
            begin
                out_last_next = 1'b0;
            end
            rfc_pkg::KIND_CRC:
            begin
                out_byte_next = crc_base;
                out_last_next = 1'b1;
                crc_next      = rfc_pkg::CRC_INIT;
            end
            rfc_pkg::KIND_ERR:
            begin
                out_byte_next = '0;
                out_last_next = 1'b1;
                out_ovf_next  = 1'b1;
                crc_next      = rfc_pkg::CRC_INIT;
            end
            default:
            begin
                crc_next = rfc_pkg::CRC_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            crc_reg       <= rfc_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg <= '0;
                cnt_reg <= bundle.count;
            end
            else if (move)
            begin
                idx_reg <= rfc_pkg::IDX_W'(idx_reg + rfc_pkg::IDX_W'(1));
            end
            if (move)
            begin
                crc_reg <= crc_next;
            end
            if (out_free)
            begin
                out_valid_reg <= move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pend_reg <= bundle;
        end
        if (move)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
            out_ovf_reg  <= out_ovf_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign out_overflow = out_ovf_reg;

endmodule

[src/response_framer_crc8.sv]
// ----------------------------------------------------------------------------
// response_framer_crc8
// Serialises response frames with a trailing CRC-8 (polynomial 0x07).
// ----------------------------------------------------------------------------
// The slave channel takes one request per item: s_tuser selects a header
// (0) or a payload byte (1). A header request yields sync byte, response
// code, status and length, followed by the CRC when the length is zero; a
// payload request yields its byte, and the last one of a frame is followed
// by the CRC. A frame larger than tx_capacity, or a length above PAYLOAD_MAX,
// yields one result with m_tuser (overflow) and m_tlast high, and its
// payload requests are dropped. The master channel carries one frame byte
// per transfer, m_tlast marking the CRC byte or the overflow result.
// The first result passes through the result queue and the output register.
// Results leave at one per cycle while the receiver does not stall; the
// single output port sets this rate. A request yields 0 to 5 results; one
// that yields none leaves the queue empty. Payload requests thus stream at
// the same rate. The next request is taken in the cycle that the final
// queued result moves to the output register. When the receiver stalls, the
// output register and the queued results hold, and s_tready stays low until
// the final queued result can move on. Reset clears the frame state, the
// queue and the output register, and loads sync_byte with 0 and tx_capacity
// with 260. The configuration channel is always ready; the user must write
// it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module response_framer_crc8 #(
    parameter int unsigned PAYLOAD_MAX = rfc_pkg::PAYLOAD_MAX
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration writes.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [rfc_pkg::CAP_W-1:0]     cfg_data,
    // Input requests.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] resp_code, [15:8] status_code, [23:16] payload_len, [31:24] data_byte
    input  logic [rfc_pkg::IN_DATA_W-1:0] s_tdata,
    // [0] command
    input  logic                          s_tuser,
    // Output frame bytes.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] out_byte
    output logic [rfc_pkg::BYTE_W-1:0]    m_tdata,
    // last
    output logic                          m_tlast,
    // [0] overflow
    output logic                          m_tuser
);

    logic [rfc_pkg::BYTE_W-1:0] sync_byte_reg;
    logic [rfc_pkg::CAP_W-1:0]  tx_capacity_reg;
    logic                       accept;
    logic                       can_load;
    rfc_pkg::bundle_t           bundle;

    // Configuration registers; the write channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg   <= rfc_pkg::SYNC_BYTE_RST;
            tx_capacity_reg <= rfc_pkg::TX_CAPACITY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rfc_pkg::CFG_SYNC_BYTE:
                begin
                    sync_byte_reg <= cfg_data[rfc_pkg::BYTE_W-1:0];
                end
                rfc_pkg::CFG_TX_CAPACITY:
                begin
                    tx_capacity_reg <= cfg_data;
                end
                default:
                begin
                    sync_byte_reg <= sync_byte_reg;
                end
            endcase
        end
    end

    // A request is taken whenever the result queue is empty or drains its
    // final entry into the output register in this cycle.
    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    rfc_frame_ctl #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_frame_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (s_tuser),
        .resp_code   (s_tdata[7:0]),
        .status_code (s_tdata[15:8]),
        .payload_len (s_tdata[23:16]),
        .data_byte   (s_tdata[31:24]),
        .sync_byte   (sync_byte_reg),
        .tx_capacity (tx_capacity_reg),
        .bundle      (bundle)
    );

    // The queue keeps the running CRC, folding in each data byte as it is
    // moved into the output register.
    rfc_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .bundle       (bundle),
        .can_load     (can_load),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_last     (m_tlast),
        .out_overflow (m_tuser)
    );

endmodule
